// File: sv/phase_to_sine_cosine_top_macros.svh
// assertion helpers for the sine/cosine pipeline
`ifndef PHASE_TO_SINE_COSINE_TOP_MACROS_SVH
`define PHASE_TO_SINE_COSINE_TOP_MACROS_SVH

// checked on the rising clock, off while reset is high
`define P2SC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock, reset included
`define P2SC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/p2sc_pkg.sv
package p2sc_pkg;

   localparam int OpW = 64;
   localparam int HalfW = OpW / 2;
   localparam int LhW = OpW + 1;
   localparam int ProdW = 2 * OpW;
   localparam int PhaseW = 64;
   localparam int CoefW = 32;
   localparam int OutW = 32;
   localparam int CsrIdxW = 3;
   localparam int NumCoef = 7;

   localparam int TableBits = 6;
   localparam int RomSize = 1 << TableBits;
   localparam int QuarterSize = RomSize / 4;
   localparam int FracW = 52;
   localparam int RomFracW = 62;
   localparam int ResW = FracW - TableBits;
   localparam int R2W = 2 * ResW - 1 - FracW;
   localparam int CoefShift = 28;
   localparam int OutShift = 22;
   localparam int TaylorLast = 21;
   localparam int PipeDepth = 18;

   typedef logic signed [OpW-1:0] op_type;
   typedef logic signed [ProdW-1:0] prod_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SIN_COEF_1,
      CSR_SIN_COEF_3,
      CSR_SIN_COEF_5,
      CSR_SIN_COEF_7,
      CSR_COS_COEF_2,
      CSR_COS_COEF_4,
      CSR_COS_COEF_6
   } csr_index_type;

   localparam logic signed [CoefW-1:0] SinCoef1Reset = 32'sd105414357;
   localparam logic signed [CoefW-1:0] SinCoef3Reset = -32'sd693598665;
   localparam logic signed [CoefW-1:0] SinCoef5Reset = 32'sd1369108894;
   localparam logic signed [CoefW-1:0] SinCoef7Reset = -32'sd1286911452;
   localparam logic signed [CoefW-1:0] CosCoef2Reset = -32'sd331168982;
   localparam logic signed [CoefW-1:0] CosCoef4Reset = 32'sd1089502340;
   localparam logic signed [CoefW-1:0] CosCoef6Reset = -32'sd1433727192;

   localparam op_type TwoPiQ59 = 64'sd3622009729038561421;
   localparam op_type OneQ52 = op_type'(1) <<< FracW;
   localparam op_type OneQ62 = op_type'(1) <<< RomFracW;
   localparam op_type RoundQ30 = op_type'(1) <<< (OutShift - 1);
   localparam logic signed [OutW-1:0] OneQ30 = 32'sh4000_0000;

   // floor(a * b / 2^sh), exact product
   function automatic op_type mul_shift(input op_type a, input op_type b, input int sh);
      prod_type p;
      p = ProdW'(a) * ProdW'(b);
      p = p >>> sh;
      return p[OpW-1:0];
   endfunction

   // quotient truncated toward zero, for the table build
   function automatic op_type div_trunc(input op_type num, input op_type den);
      logic [OpW-1:0] n_mag;
      logic [OpW-1:0] d_mag;
      logic [OpW-1:0] q;
      logic [OpW:0] rem;
      int b;
      n_mag = num[OpW-1] ? -num : num;
      d_mag = den[OpW-1] ? -den : den;
      q = '0;
      rem = '0;
      for (b = OpW - 1; b >= 0; b--) begin
         rem = {rem[OpW-1:0], n_mag[b]};
         if (rem >= {1'b0, d_mag}) begin
            rem = rem - {1'b0, d_mag};
            q[b] = 1'b1;
         end
      end
      return (num[OpW-1] ^ den[OpW-1]) ? -$signed(q) : $signed(q);
   endfunction

   // series for sin (odd) or cos (even) of a q62 angle
   function automatic op_type taylor(input op_type a, input logic odd);
      op_type a2;
      op_type term;
      op_type sum;
      int n;
      a2 = mul_shift(a, a, RomFracW);
      term = odd ? a : OneQ62;
      sum = term;
      for (n = odd ? 3 : 2; n <= TaylorLast; n += 2) begin
         term = -div_trunc(mul_shift(term, a2, RomFracW), op_type'((n - 1) * n));
         sum = sum + term;
      end
      return sum;
   endfunction

   function automatic op_type quarter_sin(input int j);
      int k;
      op_type a;
      k = (j <= QuarterSize / 2) ? j : QuarterSize - j;
      a = mul_shift(TwoPiQ59, op_type'(k), TableBits - 3);
      return taylor(a, j <= QuarterSize / 2);
   endfunction

   function automatic logic [RomSize*OpW-1:0] build_rom();
      logic [RomSize*OpW-1:0] bits;
      op_type v;
      int q;
      int j;
      int k;
      bits = '0;
      for (k = 0; k < RomSize; k++) begin
         q = k / QuarterSize;
         j = k % QuarterSize;
         v = q[0] ? quarter_sin(QuarterSize - j) : quarter_sin(j);
         bits[k*OpW +: OpW] = q[1] ? -v : v;
      end
      return bits;
   endfunction

   localparam logic [RomSize*OpW-1:0] SinRom = build_rom();

   function automatic op_type rom_read(input logic [TableBits-1:0] k);
      return SinRom[k*OpW +: OpW];
   endfunction

   function automatic op_type widen_coef(input logic signed [CoefW-1:0] c);
      return {{(OpW - CoefW - CoefShift){c[CoefW-1]}}, c, CoefShift'(0)};
   endfunction

   // clamp to plus or minus one, round to q1.30
   function automatic logic signed [OutW-1:0] finish_q30(input op_type v);
      op_type c;
      c = v;
      if (c > OneQ52) c = OneQ52;
      if (c < -OneQ52) c = -OneQ52;
      c = c + RoundQ30;
      return c[OutShift +: OutW];
   endfunction

endpackage

// File: sv/phase_to_sine_cosine_top.sv
// Sine and cosine of a 64-bit phase word, one full turn = 2^64.
// Input: a transfer happens on a rising edge with start high and busy low;
//   req_phase is sampled there. busy is always low, so a new phase may be
//   given on every cycle.
// Output: rsp_valid is high for one cycle per item, carrying rsp_sine and
//   rsp_cosine in signed q1.30, saturated to plus or minus one. Results
//   come out in transfer order; the receiver has no way to hold them, and
//   none is needed.
// Throughput: one item per cycle. Latency is set by the chain of six
//   multiplies (square of the residual, three sine polynomial steps, the
//   residual sine product, the angle-addition products), each a two-stage
//   split multiplier, plus the add and rounding registers between them.
// Configuration: csr_ready is always high; csr_index 0 to 6 selects the
//   polynomial coefficients (q7.24), other indexes are dropped. Write them
//   only while no item is in flight.
// Reset (synchronous): empties the pipeline and restores the default
//   Taylor coefficients; items in flight are dropped and no stale result is produced.
`include "phase_to_sine_cosine_top_macros.svh"

module phase_to_sine_cosine_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [p2sc_pkg::PhaseW-1:0]         req_phase,
   output logic                                rsp_valid,
   output logic signed [p2sc_pkg::OutW-1:0]    rsp_sine,
   output logic signed [p2sc_pkg::OutW-1:0]    rsp_cosine,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [p2sc_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [p2sc_pkg::CoefW-1:0]          csr_wdata
);
   import p2sc_pkg::*;

   localparam int RLast = 12;
   localparam int IdxLast = 13;
   localparam int R2First = 4;
   localparam int R2Mid = 6;
   localparam int R2Last = 9;
   localparam int CrFirst = 12;
   localparam int CrLast = 14;

   logic [PipeDepth:1] vld_in, vld_ff;

   logic signed [CoefW-1:0] sin_coef_1_in, sin_coef_1_ff;
   logic signed [CoefW-1:0] sin_coef_3_in, sin_coef_3_ff;
   logic signed [CoefW-1:0] sin_coef_5_in, sin_coef_5_ff;
   logic signed [CoefW-1:0] sin_coef_7_in, sin_coef_7_ff;
   logic signed [CoefW-1:0] cos_coef_2_in, cos_coef_2_ff;
   logic signed [CoefW-1:0] cos_coef_4_in, cos_coef_4_ff;
   logic signed [CoefW-1:0] cos_coef_6_in, cos_coef_6_ff;

   logic signed [ResW-1:0] r_in;
   logic signed [ResW-1:0] r_dly_ff [1:RLast];
   logic [TableBits-1:0] idx_in;
   logic [TableBits-1:0] idx_dly_ff [1:IdxLast];
   logic [R2W-1:0] r2_s3;
   logic [R2W-1:0] r2_dly_ff [R2First:R2Last];

   prod_type p_r2, p_sh1, p_ch1, p_sh2, p_ch2, p_sh3, p_cr, p_sr;
   prod_type p_sc, p_cs, p_cc, p_ss;

   op_type acc_s6_in, acc_s6_ff, acc_c6_in, acc_c6_ff;
   op_type acc_s9_in, acc_s9_ff, acc_c9_in, acc_c9_ff;
   op_type acc_s12_in, acc_s12_ff;
   op_type cr_in;
   op_type cr_dly_ff [CrFirst:CrLast];
   op_type sr_s14;
   op_type ts_in, ts_ff, tc_in, tc_ff;
   op_type s52_in, s52_ff, c52_in, c52_ff;
   logic signed [OutW-1:0] sine_in, sine_ff, cosine_in, cosine_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // control and configuration
   always_comb begin
      vld_in = {vld_ff[PipeDepth-1:1], start && !busy};
      sin_coef_1_in = sin_coef_1_ff;
      sin_coef_3_in = sin_coef_3_ff;
      sin_coef_5_in = sin_coef_5_ff;
      sin_coef_7_in = sin_coef_7_ff;
      cos_coef_2_in = cos_coef_2_ff;
      cos_coef_4_in = cos_coef_4_ff;
      cos_coef_6_in = cos_coef_6_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIN_COEF_1: sin_coef_1_in = $signed(csr_wdata);
            CSR_SIN_COEF_3: sin_coef_3_in = $signed(csr_wdata);
            CSR_SIN_COEF_5: sin_coef_5_in = $signed(csr_wdata);
            CSR_SIN_COEF_7: sin_coef_7_in = $signed(csr_wdata);
            CSR_COS_COEF_2: cos_coef_2_in = $signed(csr_wdata);
            CSR_COS_COEF_4: cos_coef_4_in = $signed(csr_wdata);
            CSR_COS_COEF_6: cos_coef_6_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         sin_coef_1_ff <= SinCoef1Reset;
         sin_coef_3_ff <= SinCoef3Reset;
         sin_coef_5_ff <= SinCoef5Reset;
         sin_coef_7_ff <= SinCoef7Reset;
         cos_coef_2_ff <= CosCoef2Reset;
         cos_coef_4_ff <= CosCoef4Reset;
         cos_coef_6_ff <= CosCoef6Reset;
      end else begin
         vld_ff <= vld_in;
         sin_coef_1_ff <= sin_coef_1_in;
         sin_coef_3_ff <= sin_coef_3_in;
         sin_coef_5_ff <= sin_coef_5_in;
         sin_coef_7_ff <= sin_coef_7_in;
         cos_coef_2_ff <= cos_coef_2_in;
         cos_coef_4_ff <= cos_coef_4_in;
         cos_coef_6_ff <= cos_coef_6_in;
      end
   end

   // table index rounded to nearest, residual around that point
   always_comb begin
      idx_in = req_phase[PhaseW-1 -: TableBits]
         + TableBits'(req_phase[PhaseW-1-TableBits]);
      r_in = $signed(req_phase[PhaseW-1-TableBits -: ResW]);
   end

   // residual squared
   p2sc_mul u_mul_r2 (.clock(clock), .opa(OpW'(r_dly_ff[1])), .opb(OpW'(r_dly_ff[1])),
      .prod(p_r2));
   assign r2_s3 = p_r2[FracW +: R2W];

   // first horner steps
   p2sc_mul u_mul_sh1 (.clock(clock), .opa(widen_coef(sin_coef_7_ff)), .opb(OpW'(r2_s3)),
      .prod(p_sh1));
   p2sc_mul u_mul_ch1 (.clock(clock), .opa(widen_coef(cos_coef_6_ff)), .opb(OpW'(r2_s3)),
      .prod(p_ch1));

   // second horner steps
   p2sc_mul u_mul_sh2 (.clock(clock), .opa(acc_s6_ff), .opb(OpW'(r2_dly_ff[R2Mid])),
      .prod(p_sh2));
   p2sc_mul u_mul_ch2 (.clock(clock), .opa(acc_c6_ff), .opb(OpW'(r2_dly_ff[R2Mid])),
      .prod(p_ch2));

   // last sine step and the cosine polynomial
   p2sc_mul u_mul_sh3 (.clock(clock), .opa(acc_s9_ff), .opb(OpW'(r2_dly_ff[R2Last])),
      .prod(p_sh3));
   p2sc_mul u_mul_cr (.clock(clock), .opa(OpW'(r2_dly_ff[R2Last])), .opb(acc_c9_ff),
      .prod(p_cr));

   // sine polynomial
   p2sc_mul u_mul_sr (.clock(clock), .opa(OpW'(r_dly_ff[RLast])), .opb(acc_s12_ff),
      .prod(p_sr));
   assign sr_s14 = p_sr[FracW +: OpW];

   // angle addition
   p2sc_mul u_mul_sc (.clock(clock), .opa(ts_ff), .opb(cr_dly_ff[CrLast]), .prod(p_sc));
   p2sc_mul u_mul_cs (.clock(clock), .opa(tc_ff), .opb(sr_s14), .prod(p_cs));
   p2sc_mul u_mul_cc (.clock(clock), .opa(tc_ff), .opb(cr_dly_ff[CrLast]), .prod(p_cc));
   p2sc_mul u_mul_ss (.clock(clock), .opa(ts_ff), .opb(sr_s14), .prod(p_ss));

   always_comb begin
      acc_s6_in = widen_coef(sin_coef_5_ff) + p_sh1[FracW +: OpW];
      acc_c6_in = widen_coef(cos_coef_4_ff) + p_ch1[FracW +: OpW];
      acc_s9_in = widen_coef(sin_coef_3_ff) + p_sh2[FracW +: OpW];
      acc_c9_in = widen_coef(cos_coef_2_ff) + p_ch2[FracW +: OpW];
      acc_s12_in = widen_coef(sin_coef_1_ff) + p_sh3[FracW +: OpW];
      cr_in = OneQ52 + p_cr[FracW +: OpW];
      ts_in = rom_read(idx_dly_ff[IdxLast]);
      tc_in = rom_read(TableBits'(QuarterSize) - idx_dly_ff[IdxLast]);
      s52_in = p_sc[RomFracW +: OpW] + p_cs[RomFracW +: OpW];
      c52_in = p_cc[RomFracW +: OpW] - p_ss[RomFracW +: OpW];
      sine_in = finish_q30(s52_ff);
      cosine_in = finish_q30(c52_ff);
   end

   always_ff @(posedge clock) begin
      r_dly_ff[1] <= r_in;
      for (int k = 2; k <= RLast; k++) begin
         r_dly_ff[k] <= r_dly_ff[k-1];
      end
      idx_dly_ff[1] <= idx_in;
      for (int k = 2; k <= IdxLast; k++) begin
         idx_dly_ff[k] <= idx_dly_ff[k-1];
      end
      r2_dly_ff[R2First] <= r2_s3;
      for (int k = R2First + 1; k <= R2Last; k++) begin
         r2_dly_ff[k] <= r2_dly_ff[k-1];
      end
      cr_dly_ff[CrFirst] <= cr_in;
      for (int k = CrFirst + 1; k <= CrLast; k++) begin
         cr_dly_ff[k] <= cr_dly_ff[k-1];
      end
      acc_s6_ff <= acc_s6_in;
      acc_c6_ff <= acc_c6_in;
      acc_s9_ff <= acc_s9_in;
      acc_c9_ff <= acc_c9_in;
      acc_s12_ff <= acc_s12_in;
      ts_ff <= ts_in;
      tc_ff <= tc_in;
      s52_ff <= s52_in;
      c52_ff <= c52_in;
      sine_ff <= sine_in;
      cosine_ff <= cosine_in;
   end

   assign rsp_valid = vld_ff[PipeDepth];
   assign rsp_sine = sine_ff;
   assign rsp_cosine = cosine_ff;

   `P2SC_ASSERT(a_rsp_follows_transfer, rsp_valid |-> $past(start && !busy, PipeDepth), "result without a matching transfer")
   `P2SC_ASSERT(a_rsp_saturated, rsp_valid |-> (rsp_sine >= -OneQ30 && rsp_sine <= OneQ30 && rsp_cosine >= -OneQ30 && rsp_cosine <= OneQ30), "result outside plus or minus one")
   `P2SC_ASSERT(a_zero_phase, (rsp_valid && $past(start && !busy && req_phase == '0, PipeDepth)) |-> (rsp_sine == '0 && rsp_cosine == OneQ30), "zero phase not giving sine 0 cosine 1")
   `P2SC_ASSERT_ALWAYS(a_reset_flush, reset |=> (!rsp_valid && vld_ff == '0), "pipeline not empty after reset")

endmodule

// File: sv/p2sc_mul.sv
module p2sc_mul (
   input  logic               clock,
   input  p2sc_pkg::op_type   opa,
   input  p2sc_pkg::op_type   opb,
   output p2sc_pkg::prod_type prod
);
   import p2sc_pkg::*;

   logic [OpW-1:0] ll_in, ll_ff;
   logic signed [LhW-1:0] lh_in, lh_ff;
   logic signed [LhW-1:0] hl_in, hl_ff;
   logic signed [OpW-1:0] hh_in, hh_ff;
   prod_type ll_x, lh_x, hl_x, hh_x;
   prod_type prod_in, prod_ff;

   // partial products of the 32-bit halves
   always_comb begin
      ll_in = OpW'(opa[HalfW-1:0]) * OpW'(opb[HalfW-1:0]);
      lh_in = LhW'($signed({1'b0, opa[HalfW-1:0]})) * LhW'($signed(opb[OpW-1:HalfW]));
      hl_in = LhW'($signed(opa[OpW-1:HalfW])) * LhW'($signed({1'b0, opb[HalfW-1:0]}));
      hh_in = OpW'($signed(opa[OpW-1:HalfW])) * OpW'($signed(opb[OpW-1:HalfW]));
   end

   always_comb begin
      ll_x = ProdW'(ll_ff);
      lh_x = ProdW'(lh_ff);
      hl_x = ProdW'(hl_ff);
      hh_x = ProdW'(hh_ff);
      prod_in = (hh_x << OpW) + (lh_x << HalfW) + (hl_x << HalfW) + ll_x;
   end

   always_ff @(posedge clock) begin
      ll_ff <= ll_in;
      lh_ff <= lh_in;
      hl_ff <= hl_in;
      hh_ff <= hh_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
